// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent check on the rising edge, off while in reset
`define RTC_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// same-cycle implication
`define RTC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    `RTC_ASSERT(lbl, ck, rn, (ante) |-> (cons), msg)

// next-cycle implication
`define RTC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    `RTC_ASSERT(lbl, ck, rn, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/rtc_pkg.sv =====
package rtc_pkg;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int MAG_W  = 16;   // |x| up to 2^15
    localparam int SQ_W   = 31;   // x^2 up to 2^30
    localparam int PROD_W = 46;   // |x|^3 up to 2^45
    localparam int M27_W  = 20;   // 27*|x| below 2^20

    localparam int IN_FRAC_BITS_DEF  = 12;
    localparam int OUT_FRAC_BITS_DEF = 14;

    typedef struct packed {
        logic valid;
        logic neg;
        logic one;    // magnitude result is exactly 1.0
    } ctl_t;

    // denominator 27*2^2F + 9*x^2
    function automatic int e_width(input int f);
        int a;
        a = 2 * f + 5;
        return ((a > 34) ? a : 34) + 1;
    endfunction

    // numerator 27*|x|*2^2F + |x|^3
    function automatic int n_width(input int f);
        int a;
        a = 2 * f + M27_W;
        return ((a > PROD_W) ? a : PROD_W) + 1;
    endfunction

    // compare width for the clamp threshold 5*2^F
    function automatic int cmp_width(input int f);
        int a;
        a = f + 3;
        return (a > MAG_W) ? a : MAG_W;
    endfunction

endpackage

// ===== rtl/core/rtc_front.sv =====
module rtc_front #(
    parameter int IN_FRAC_BITS  = rtc_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = rtc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic signed [rtc_pkg::IN_W-1:0]               sample_in,
    output rtc_pkg::ctl_t                                 ctl_out,
    output logic [rtc_pkg::e_width(IN_FRAC_BITS)-1:0]     rem_out,
    output logic [rtc_pkg::e_width(IN_FRAC_BITS)-1:0]     div_out,
    output logic [OUT_FRAC_BITS-1:0]                      dq_out
);
    import rtc_pkg::*;

    localparam int E_W = e_width(IN_FRAC_BITS);
    localparam int N_W = n_width(IN_FRAC_BITS);
    localparam int C_W = cmp_width(IN_FRAC_BITS);
    localparam int L_W = IN_FRAC_BITS + OUT_FRAC_BITS;
    localparam logic [C_W-1:0] FIVE    = C_W'(5) << IN_FRAC_BITS;
    localparam logic [E_W-1:0] A_CONST = E_W'(27) << (2 * IN_FRAC_BITS);

    ctl_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    ctl_t c1_next, c5_next;

    logic [MAG_W-1:0]  raw;
    logic [MAG_W-1:0]  mag1_reg, mag1_next, mag2_reg;
    logic [31:0]       sq_full;
    logic [SQ_W-1:0]   sq2_reg, sq2_next;
    logic [PROD_W-1:0] prod3_reg, prod3_next;
    logic [M27_W-1:0]  m27_3_reg, m27_3_next;
    logic [E_W-1:0]    e3_reg, e3_next, e4_reg, e5_reg;
    logic [N_W-1:0]    n4_reg, n4_next;
    logic [N_W-1:0]    r0;
    logic              ge;
    logic [E_W-1:0]    rem5_reg, rem5_next;
    logic [L_W-1:0]    lo_ext;
    logic [OUT_FRAC_BITS-1:0] dq5_reg, dq5_next;

    // stage 1: magnitude and early clamp
    assign raw = sample_in;
    always_comb
    begin
        mag1_next     = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;
        c1_next.valid = in_valid;
        c1_next.neg   = raw[MAG_W-1];
        c1_next.one   = C_W'(mag1_next) > FIVE;
    end

    // stage 2: square
    assign sq_full  = 32'(mag1_reg) * 32'(mag1_reg);
    assign sq2_next = sq_full[SQ_W-1:0];

    // stage 3: cube, 27*|x| and denominator
    always_comb
    begin
        prod3_next = PROD_W'(mag2_reg) * PROD_W'(sq2_reg);
        m27_3_next = M27_W'(mag2_reg) * M27_W'(27);
        e3_next    = A_CONST + (E_W'(sq2_reg) << 3) + E_W'(sq2_reg);
    end

    // stage 4: numerator
    assign n4_next = (N_W'(m27_3_reg) << (2 * IN_FRAC_BITS)) + N_W'(prod3_reg);

    // stage 5: quotient >= 1 test, starting remainder and dividend bits
    always_comb
    begin
        r0            = n4_reg >> IN_FRAC_BITS;
        ge            = r0 >= N_W'(e4_reg);
        rem5_next     = r0[E_W-1:0];
        lo_ext        = {n4_reg[IN_FRAC_BITS-1:0], {OUT_FRAC_BITS{1'b0}}};
        dq5_next      = lo_ext[L_W-1:IN_FRAC_BITS];
        c5_next       = c4_reg;
        c5_next.one   = c4_reg.one | ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            c5_reg <= c5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag1_next;
            mag2_reg  <= mag1_reg;
            sq2_reg   <= sq2_next;
            prod3_reg <= prod3_next;
            m27_3_reg <= m27_3_next;
            e3_reg    <= e3_next;
            n4_reg    <= n4_next;
            e4_reg    <= e3_reg;
            rem5_reg  <= rem5_next;
            dq5_reg   <= dq5_next;
            e5_reg    <= e4_reg;
        end
    end

    assign ctl_out = c5_reg;
    assign rem_out = rem5_reg;
    assign div_out = e5_reg;
    assign dq_out  = dq5_reg;

endmodule

// ===== rtl/core/rtc_div_stage.sv =====
`include "assert_macros.svh"

module rtc_div_stage #(
    parameter int DIV_W = rtc_pkg::e_width(rtc_pkg::IN_FRAC_BITS_DEF),
    parameter int Q_W   = rtc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  rtc_pkg::ctl_t        ctl_in,
    input  logic [DIV_W-1:0]     rem_in,
    input  logic [DIV_W-1:0]     div_in,
    input  logic [Q_W-1:0]       dq_in,
    output rtc_pkg::ctl_t        ctl_out,
    output logic [DIV_W-1:0]     rem_out,
    output logic [DIV_W-1:0]     div_out,
    output logic [Q_W-1:0]       dq_out
);
    import rtc_pkg::*;

    ctl_t             ctl_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic [DIV_W-1:0] rem_reg, rem_next, div_reg;
    logic [Q_W-1:0]   dq_reg, dq_next;

    // one restoring step: dividend bits leave at the top, quotient bits enter at the bottom
    always_comb
    begin
        trial    = {rem_in, dq_in[Q_W-1]};
        diff     = trial - {1'b0, div_in};
        fits     = trial >= {1'b0, div_in};
        rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dq_next  = {dq_in[Q_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            div_reg <= div_in;
            dq_reg  <= dq_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign div_out = div_reg;
    assign dq_out  = dq_reg;

    // partial remainder stays below the divisor on the live path
    `RTC_ASSERT_IMP(a_rem_below_div, clk, rst_n, ctl_in.valid && !ctl_in.one, rem_in < div_in, "div stage: remainder not below divisor")

endmodule

// ===== rtl/core/rtc_out.sv =====
`include "assert_macros.svh"

module rtc_out #(
    parameter int OUT_FRAC_BITS = rtc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rtc_pkg::ctl_t                    ctl_in,
    input  logic [OUT_FRAC_BITS-1:0]         q_in,
    output logic                             en,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [rtc_pkg::OUT_W-1:0] tanh_out
);
    import rtc_pkg::*;

    localparam int M_W = OUT_FRAC_BITS + 1;

    logic [M_W-1:0]       mag_w;
    logic [M_W+OUT_W-1:0] mag_x;
    logic [OUT_W-1:0]     mag16;
    logic [OUT_W-1:0]     res;
    logic                 take;
    logic                 pipe_v;

    logic             out_v_reg, out_v_next;
    logic             skid_v_reg, skid_v_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic [OUT_W-1:0] skid_data_reg, skid_data_next;

    // select 1.0 or quotient, apply sign, keep low 16 bits
    always_comb
    begin
        mag_w = ctl_in.one ? (M_W'(1) << OUT_FRAC_BITS) : {1'b0, q_in};
        mag_x = {{OUT_W{1'b0}}, mag_w};
        mag16 = mag_x[OUT_W-1:0];
        res   = ctl_in.neg ? (OUT_W'(0) - mag16) : mag16;
    end

    // pipeline only moves while the skid slot is free
    assign en     = !skid_v_reg;
    assign take   = !out_v_reg || out_ready;
    assign pipe_v = ctl_in.valid && en;

    always_comb
    begin
        out_v_next     = out_v_reg;
        out_data_next  = out_data_reg;
        skid_v_next    = skid_v_reg;
        skid_data_next = skid_data_reg;
        if (take)
        begin
            if (skid_v_reg)
            begin
                out_v_next    = 1'b1;
                out_data_next = skid_data_reg;
                skid_v_next   = 1'b0;
            end
            else
            begin
                out_v_next    = pipe_v;
                out_data_next = res;
            end
        end
        else if (pipe_v)
        begin
            skid_v_next    = 1'b1;
            skid_data_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_v_reg;
    assign tanh_out  = out_data_reg;

    `RTC_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_v_reg, out_v_reg, "out: skid holds a request while output is empty")
    `RTC_ASSERT_NXT(a_skid_catches, clk, rst_n, out_v_reg && !out_ready && pipe_v, skid_v_reg, "out: stalled result not caught by skid")

endmodule

// ===== rtl/core/rational_tanh_clamped_core.sv =====
// channel | direction | signals                        | handshake
// input   | in        | sample_in (Q4.12 signed)       | in_valid / in_ready
// output  | out       | tanh_out  (Q2.14 signed)       | out_valid / out_ready
//
// one request per cycle while in_ready is high; five front stages,
// one restoring divider stage per quotient bit, one output register
// in_ready is registered; it drops only while both output register and skid slot hold results
// reset clears the valid and control bits only; data registers are left as they are
// a stall freezes the front and divider stages at once and nothing is dropped or repeated
`include "assert_macros.svh"

module rational_tanh_clamped_core #(
    parameter int IN_FRAC_BITS  = rtc_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = rtc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [rtc_pkg::IN_W-1:0]  sample_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [rtc_pkg::OUT_W-1:0] tanh_out
);
    import rtc_pkg::*;

    localparam int E_W = e_width(IN_FRAC_BITS);

    logic en;
    ctl_t ctl_a [0:OUT_FRAC_BITS];
    logic [E_W-1:0] rem_a [0:OUT_FRAC_BITS];
    logic [E_W-1:0] div_a [0:OUT_FRAC_BITS];
    logic [OUT_FRAC_BITS-1:0] dq_a [0:OUT_FRAC_BITS];

    rtc_front #(
        .IN_FRAC_BITS  (IN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .sample_in (sample_in),
        .ctl_out   (ctl_a[0]),
        .rem_out   (rem_a[0]),
        .div_out   (div_a[0]),
        .dq_out    (dq_a[0])
    );

    for (genvar k = 0; k < OUT_FRAC_BITS; k++)
    begin : g_div
        rtc_div_stage #(
            .DIV_W (E_W),
            .Q_W   (OUT_FRAC_BITS)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_a[k]),
            .rem_in  (rem_a[k]),
            .div_in  (div_a[k]),
            .dq_in   (dq_a[k]),
            .ctl_out (ctl_a[k+1]),
            .rem_out (rem_a[k+1]),
            .div_out (div_a[k+1]),
            .dq_out  (dq_a[k+1])
        );
    end

    rtc_out #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl_a[OUT_FRAC_BITS]),
        .q_in      (dq_a[OUT_FRAC_BITS]),
        .en        (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tanh_out  (tanh_out)
    );

    assign in_ready = en;

    // final remainder is a proper remainder when the quotient is used
    `RTC_ASSERT_IMP(a_final_rem, clk, rst_n, ctl_a[OUT_FRAC_BITS].valid && !ctl_a[OUT_FRAC_BITS].one, rem_a[OUT_FRAC_BITS] < div_a[OUT_FRAC_BITS], "core: final remainder not below divisor")
    // result within -1.0 .. +1.0 whenever 1.0 fits the output field
    `RTC_ASSERT_IMP(a_out_range, clk, rst_n, out_valid && (OUT_FRAC_BITS < 15), (int'(tanh_out) <= (1 << OUT_FRAC_BITS)) && (int'(tanh_out) >= -(1 << OUT_FRAC_BITS)), "core: result outside -1.0 .. +1.0")

endmodule

// ===== verif/tanh_checker.sv =====
`timescale 1ns / 100ps

module tanh_checker #(
    parameter int IN_FRAC_BITS  = rtc_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = rtc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic signed [rtc_pkg::IN_W-1:0]  sample_in,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic signed [rtc_pkg::OUT_W-1:0] tanh_out,
    output int                               mismatch_count,
    output int                               pending_count
);

    logic signed [rtc_pkg::OUT_W-1:0] pending_tanh[$];
    logic signed [rtc_pkg::OUT_W-1:0] oldest_tanh;

    // x*(27+x^2)/(27+9x^2), magnitude truncated, sign applied afterwards
    function automatic logic signed [rtc_pkg::OUT_W-1:0] pade_tanh(
        input logic signed [rtc_pkg::IN_W-1:0] x
    );
        logic [63:0] mag;
        logic [63:0] base27;
        logic [63:0] mag_sq;
        logic [63:0] numer;
        logic [63:0] denom;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] res;
        int          extra_bits;
        int          i;
        mag = x[rtc_pkg::IN_W-1] ? ((64'd1 << rtc_pkg::IN_W) - {48'd0, x}) : {48'd0, x};
        if (mag > (64'd5 << IN_FRAC_BITS))
        begin
            res = 64'd1 << OUT_FRAC_BITS;
        end
        else
        begin
            base27 = 64'd27 << (2 * IN_FRAC_BITS);
            mag_sq = mag * mag;
            numer  = mag * (base27 + mag_sq);
            denom  = base27 + 64'd9 * mag_sq;
            if ((numer >> IN_FRAC_BITS) >= denom)
            begin
                res = 64'd1 << OUT_FRAC_BITS;
            end
            else
            begin
                if (OUT_FRAC_BITS >= IN_FRAC_BITS)
                begin
                    extra_bits = OUT_FRAC_BITS - IN_FRAC_BITS;
                end
                else
                begin
                    numer      = numer >> (IN_FRAC_BITS - OUT_FRAC_BITS);
                    extra_bits = 0;
                end
                quo = numer / denom;
                rem = numer % denom;
                for (i = 0; i < extra_bits; i++)
                begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= denom)
                    begin
                        rem = rem - denom;
                        quo = quo | 64'd1;
                    end
                end
                res = quo;
            end
        end
        if (x[rtc_pkg::IN_W-1])
        begin
            res = 64'd0 - res;
        end
        return res[rtc_pkg::OUT_W-1:0];
    endfunction

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_tanh.size() == 0)
                begin
                    $error("tanh_out: unexpected result %0d with no request waiting", tanh_out);
                    mismatch_count++;
                end
                else
                begin
                    oldest_tanh = pending_tanh.pop_front();
                    if (tanh_out !== oldest_tanh)
                    begin
                        $error("tanh_out mismatch: expected %0d, actual %0d",
                               oldest_tanh, tanh_out);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_tanh.push_back(pade_tanh(sample_in));
            end
            pending_count = pending_tanh.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int IN_FRAC  = rtc_pkg::IN_FRAC_BITS_DEF;
    localparam int OUT_FRAC = rtc_pkg::OUT_FRAC_BITS_DEF;
    localparam int LATENCY  = OUT_FRAC + 6;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 500;
    localparam int FIVE_Q12 = 5 << IN_FRAC;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic signed [rtc_pkg::IN_W-1:0]  sample_in;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [rtc_pkg::OUT_W-1:0] tanh_out;
    int                               mismatch_count;
    int                               pending_count;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_asks;
    int hold_seen;

    logic signed [rtc_pkg::IN_W-1:0] directed_samples[] = '{
        16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
        16'sd20480, -16'sd20480, 16'sd20481, -16'sd20481, 16'sd20479, -16'sd20479,
        16'sd12288, -16'sd12288, 16'sd4096, -16'sd4096, 16'sd16384, -16'sd16384,
        16'sd2048, -16'sd2, 16'sd21845, -16'sd21846, 16'sd8192, -16'sd8192
    };

    rational_tanh_clamped_core #(
        .IN_FRAC_BITS  (IN_FRAC),
        .OUT_FRAC_BITS (OUT_FRAC)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample_in (sample_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tanh_out  (tanh_out)
    );

    tanh_checker #(
        .IN_FRAC_BITS  (IN_FRAC),
        .OUT_FRAC_BITS (OUT_FRAC)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_in      (sample_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tanh_out       (tanh_out),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // weighted toward the rational range, the clamp boundary and the saturation knee
    function automatic logic signed [rtc_pkg::IN_W-1:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0, 1:    v = $urandom;
            2, 3, 4, 5: v = int'($urandom_range(2 * FIVE_Q12)) - FIVE_Q12;
            6:       v = FIVE_Q12 + int'($urandom_range(8)) - 4;
            7:       v = int'($urandom_range(511)) - 256;
            8:       v = 10240 + int'($urandom_range(4096));
            default: v = 32767 - int'($urandom_range(16));
        endcase
        if (v > 0 && $urandom_range(1) == 1)
        begin
            v = -v;
        end
        return v[rtc_pkg::IN_W-1:0];
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_sample(input logic signed [rtc_pkg::IN_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            sample_in <= pick_sample();
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        out_ready = 1'b0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int phase;
        int n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample_in      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks      = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (directed_samples[i])
            send_sample(directed_samples[i]);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while requests keep coming, fills the pipe
                if (phase == 0 && n == 100)
                    hold_asks <= hold_asks + 1;
                send_sample(pick_sample());
            end
            if (phase == 1)
                drain_results();
        end

        drain_results();
        repeat (LATENCY + 10) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
